// ===== design/pfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsf_pkg: shared types and constants of the printf subset formatter
// Opcodes, parser modes, the job word between front and back, character
// tables and the decimal weight table.
// ----------------------------------------------------------------------------
package pfsf_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int COUNT_W = 31;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LPAREN = 8'h28;

	typedef enum logic [2:0] {
		OP_FMT    = 3'd0,
		OP_INT    = 3'd1,
		OP_STR    = 3'd2,
		OP_NULL   = 3'd3,
		OP_FINISH = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		MD_NORMAL,
		MD_PCT,
		MD_STR_WAIT,
		MD_STR_RUN,
		MD_DEC,
		MD_HEX
	} mode_t;

	typedef enum logic [2:0] {
		JOB_CHAR,
		JOB_DEC,
		JOB_HEX,
		JOB_NULL,
		JOB_TOTAL,
		JOB_PCT_TOTAL
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  ch;
		logic [31:0] word;  // magnitude for decimal, raw bits for hex
		logic        neg;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DEC,
		BK_HEX,
		BK_NULL,
		BK_TOTAL
	} back_state_t;

	function automatic logic [31:0] pow10(input logic [3:0] p);
		logic [31:0] r;
		unique case (p)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'b0, n};
		end else begin
			r = 8'h57 + {4'b0, n};
		end
		return r;
	endfunction

	function automatic logic [7:0] null_char(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'h28;
			3'd1: r = 8'h6E;
			3'd2: r = 8'h75;
			3'd3: r = 8'h6C;
			3'd4: r = 8'h6C;
			3'd5: r = 8'h29;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== design/printf_subset_formatter.sv =====
// ----------------------------------------------------------------------------
// printf_subset_formatter: streaming formatter for %s, %d and %x
// Input items carry format bytes, arguments and finish requests; results
// are output characters with a running count, and the count at finish.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive opcode, data_byte and arg_word with push; a word is
//   taken at a clock edge where push is high and full is low. The parser
//   takes one word a cycle while the job queue has room.
//   Result channel: while empty is low the oldest result word is on
//   out_kind, out_char, total_count and last; pop takes it.
//   Path: an item goes into the job queue, and the generator registers its
//   first result word in the output register; a non-negative decimal is
//   loaded first, with no word. Throughput: one character a cycle from the
//   generator while pop keeps up. A decimal argument is loaded (a minus sign
//   if negative), then gives its digits; a hex argument its nibbles; a null
//   string six characters; other items one word, a finish after a pending
//   percent a percent and the total. The generator sets the rate.
//   Reset clears the parser mode, the job queue, the count and the output
//   register. When pop stays low the result word holds, the generator stops
//   and the queue fills until full rises.
// ----------------------------------------------------------------------------
module printf_subset_formatter
	import pfsf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         opcode,
	input  logic [7:0]         data_byte,
	input  logic [31:0]        arg_word,
	output logic               empty,
	input  logic               pop,
	output logic               out_kind,
	output logic [7:0]         out_char,
	output logic [COUNT_W-1:0] total_count,
	output logic               last
);

	logic take;
	logic job_valid;
	job_t job_in;
	job_t job_out;
	logic job_empty;
	logic job_pop;

	assign take = push && !full;

	pfsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.opcode    (opcode),
		.data_byte (data_byte),
		.arg_word  (arg_word),
		.job_valid (job_valid),
		.job       (job_in)
	);

	pfsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take && job_valid),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	pfsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (job_empty),
		.job         (job_out),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.out_kind    (out_kind),
		.out_char    (out_char),
		.total_count (total_count),
		.last        (last)
	);

endmodule

// ===== design/pfsf_front.sv =====
// ----------------------------------------------------------------------------
// pfsf_front: format parser
// Tracks the parser mode, drops out-of-place items and turns every item that
// produces output into one job for the back end.
// ----------------------------------------------------------------------------
module pfsf_front
	import pfsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [2:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [31:0] arg_word,
	output logic        job_valid,
	output job_t        job
);

	mode_t mode_q;
	mode_t mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_NORMAL;
		end else if (take) begin
			mode_q <= mode_d;
		end
	end

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		unique case (opcode)
			OP_FMT: begin
				if (data_byte != 8'd0) begin
					if (mode_q == MD_NORMAL) begin
						if (data_byte == CH_PCT) begin
							mode_d = MD_PCT;
						end
					end else if (mode_q == MD_PCT) begin
						priority if (data_byte == CH_S) begin
							mode_d = MD_STR_WAIT;
						end else if (data_byte == CH_D) begin
							mode_d = MD_DEC;
						end else if (data_byte == CH_X) begin
							mode_d = MD_HEX;
						end else begin
							mode_d = MD_NORMAL;
						end
					end
				end
			end
			OP_INT: begin
				if (mode_q == MD_DEC || mode_q == MD_HEX) begin
					mode_d = MD_NORMAL;
				end
			end
			OP_STR: begin
				if (mode_q == MD_STR_WAIT || mode_q == MD_STR_RUN) begin
					mode_d = (data_byte == 8'd0) ? MD_NORMAL : MD_STR_RUN;
				end
			end
			OP_NULL: begin
				if (mode_q == MD_STR_WAIT) begin
					mode_d = MD_NORMAL;
				end
			end
			OP_FINISH: mode_d = MD_NORMAL;
			default: mode_d = mode_q;
		endcase
	end

	// Job generation.
	always_comb begin
		job_valid = 1'b0;
		job.kind  = JOB_CHAR;
		job.ch    = data_byte;
		job.word  = arg_word;
		job.neg   = 1'b0;
		unique case (opcode)
			OP_FMT: begin
				if (data_byte != 8'd0) begin
					if (mode_q == MD_NORMAL) begin
						job_valid = (data_byte != CH_PCT);
					end else if (mode_q == MD_PCT) begin
						job_valid = (data_byte != CH_S) && (data_byte != CH_D) &&
							(data_byte != CH_X);
					end
				end
			end
			OP_INT: begin
				if (mode_q == MD_DEC) begin
					job_valid = 1'b1;
					job.kind  = JOB_DEC;
					job.neg   = arg_word[31];
					job.word  = arg_word[31] ? (32'd0 - arg_word) : arg_word;
				end else if (mode_q == MD_HEX) begin
					job_valid = 1'b1;
					job.kind  = JOB_HEX;
				end
			end
			OP_STR: begin
				job_valid = (mode_q == MD_STR_WAIT || mode_q == MD_STR_RUN) &&
					(data_byte != 8'd0);
			end
			OP_NULL: begin
				job_valid = (mode_q == MD_STR_WAIT);
				job.kind  = JOB_NULL;
			end
			OP_FINISH: begin
				job_valid = 1'b1;
				job.kind  = (mode_q == MD_PCT) ? JOB_PCT_TOTAL : JOB_TOTAL;
			end
			default: job_valid = 1'b0;
		endcase
	end

endmodule

// ===== design/pfsf_queue.sv =====
// ----------------------------------------------------------------------------
// pfsf_queue: job queue
// A small first-in first-out queue of jobs between the parser and the
// character generator.
// ----------------------------------------------------------------------------
module pfsf_queue
	import pfsf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output job_t rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/pfsf_back.sv =====
// ----------------------------------------------------------------------------
// pfsf_back: character generator
// Expands jobs into characters one per cycle while pop keeps up, keeps the
// saturating character count and holds the result word in an output register.
// ----------------------------------------------------------------------------
module pfsf_back
	import pfsf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  job_t                job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output logic                out_kind,
	output logic [7:0]          out_char,
	output logic [COUNT_W-1:0]  total_count,
	output logic                last
);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [31:0]        mag_q;
	logic [31:0]        mag_d;
	logic [3:0]         pos_q;
	logic [3:0]         pos_d;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_inc;
	logic               out_valid_q;
	logic               adv;
	logic               take;

	logic               emit;
	logic               e_kind;
	logic [7:0]         e_char;
	logic               e_last;

	logic [34:0]        diff [1:9];
	logic [3:0]         digit;
	logic [31:0]        mag_rem;
	logic [3:0]         dec_start;
	logic [3:0]         hex_start;
	logic [3:0]         nib;

	assign adv     = !out_valid_q || pop;
	assign take    = (state_q == BK_IDLE) && !job_empty && adv;
	assign job_pop = take;
	assign empty   = !out_valid_q;
	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign nib     = mag_q[{pos_q[2:0], 2'b00} +: 4];

	// One decimal digit a cycle while the output advances: try every multiple of
	// the current power of ten and keep the largest that does not exceed the remaining magnitude.
	always_comb begin
		digit   = 4'd0;
		mag_rem = mag_q;
		for (int k = 1; k <= 9; k++) begin
			diff[k] = {3'b000, mag_q} - 35'(34'(pow10(pos_q)) * 34'(k));
			if (!diff[k][34]) begin
				digit   = 4'(k);
				mag_rem = diff[k][31:0];
			end
		end
	end

	// Start positions: number of decimal digits minus one, and the highest
	// nonzero nibble.
	always_comb begin
		dec_start = 4'd0;
		hex_start = 4'd0;
		for (int p = 1; p <= 9; p++) begin
			if (job.word >= pow10(4'(p))) begin
				dec_start = dec_start + 4'd1;
			end
		end
		for (int i = 1; i < 8; i++) begin
			if (job.word[4*i +: 4] != 4'd0) begin
				hex_start = 4'(i);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		mag_d   = mag_q;
		pos_d   = pos_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					mag_d = job.word;
					unique case (job.kind)
						JOB_PCT_TOTAL: state_d = BK_TOTAL;
						JOB_NULL: begin
							state_d = BK_NULL;
							pos_d   = 4'd1;
						end
						JOB_DEC: begin
							state_d = BK_DEC;
							pos_d   = dec_start;
						end
						JOB_HEX: begin
							state_d = BK_HEX;
							pos_d   = hex_start;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_DEC: begin
				if (adv) begin
					mag_d = mag_rem;
					pos_d = pos_q - 4'd1;
					if (pos_q == 4'd0) begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_HEX: begin
				if (adv) begin
					pos_d = pos_q - 4'd1;
					if (pos_q == 4'd0) begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_NULL: begin
				if (adv) begin
					pos_d = pos_q + 4'd1;
					if (pos_q == 4'd5) begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_TOTAL: begin
				if (adv) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Emitted word.
	always_comb begin
		emit   = 1'b0;
		e_kind = 1'b0;
		e_char = 8'd0;
		e_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					unique case (job.kind)
						JOB_CHAR: begin
							emit   = 1'b1;
							e_char = job.ch;
							e_last = 1'b1;
						end
						JOB_TOTAL: begin
							emit   = 1'b1;
							e_kind = 1'b1;
							e_last = 1'b1;
						end
						JOB_PCT_TOTAL: begin
							emit   = 1'b1;
							e_char = CH_PCT;
						end
						JOB_NULL: begin
							emit   = 1'b1;
							e_char = CH_LPAREN;
						end
						JOB_DEC: begin
							emit   = job.neg;
							e_char = CH_MINUS;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			BK_DEC: begin
				emit   = adv;
				e_char = CH_ZERO + {4'b0, digit};
				e_last = (pos_q == 4'd0);
			end
			BK_HEX: begin
				emit   = adv;
				e_char = hex_char(nib);
				e_last = (pos_q == 4'd0);
			end
			BK_NULL: begin
				emit   = adv;
				e_char = null_char(pos_q[2:0]);
				e_last = (pos_q == 4'd5);
			end
			BK_TOTAL: begin
				emit   = adv;
				e_kind = 1'b1;
				e_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				cnt_q <= e_kind ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= mag_d;
		pos_q <= pos_d;
		if (emit) begin
			out_kind    <= e_kind;
			out_char    <= e_char;
			total_count <= e_kind ? cnt_q : cnt_inc;
			last        <= e_last;
		end
	end

endmodule

// ===== design/pfsf_checker.sv =====
// ----------------------------------------------------------------------------
// pfsf_checker: port checks of the formatter
// Watches the result channel of the top level and flags words that break
// its rules.
// ----------------------------------------------------------------------------
module pfsf_checker
	import pfsf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               out_kind,
	input logic [7:0]         out_char,
	input logic [COUNT_W-1:0] total_count,
	input logic               last
);

	// A waiting result word that is not taken stays unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_kind) && $stable(out_char) &&
		$stable(total_count) && $stable(last))
		else $error("result word changed while stalled");

	// The total closes the results of a finish.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind |-> last)
		else $error("total word not marked last");

	// A total word carries no character.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_kind |-> out_char == 8'd0)
		else $error("total word with a character");

	// A character word counts at least itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_kind |-> total_count != '0)
		else $error("character word with zero count");

endmodule

bind printf_subset_formatter pfsf_checker u_pfsf_checker (.*);
